// ===== src/histogram_ks_distance_top_defines.svh =====
// Assertion macros shared by the histogram KS distance block.
`ifndef HISTOGRAM_KS_DISTANCE_TOP_DEFINES_SVH
`define HISTOGRAM_KS_DISTANCE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define HKS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hks check failed");
// Implication with the consequent checked in the next cycle.
`define HKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hks check failed");
`endif

// ===== src/hks_pkg.sv =====
// Package: types, constants and command codes of the histogram KS distance block.
package hks_pkg;
  localparam int Bins = 256;
  localparam int BinW = $clog2(Bins);
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  // Classified operation from front to back.
  typedef struct packed {
    cmd_t            cmd;
    logic            set_sel;
    logic            reject;
    logic [BinW-1:0] bin;
  } op_t;
endpackage

// ===== src/hks_front.sv =====
// Front end: accept items and compute the bin index by iterative division.
module hks_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              in_set_select,
  input  logic signed [23:0] in_sample_value,
  input  logic signed [23:0] range_low,
  input  logic signed [23:0] range_high,
  output logic              op_valid,
  input  logic              op_ready,
  output hks_pkg::op_t      op_data
);
  localparam int NumW = 25 + hks_pkg::BinW;
  localparam int CntW = $clog2(NumW + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_OUT  = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  hks_pkg::op_t        op_r, op_nxt;
  logic [NumW-1:0]     quo_r, quo_nxt;
  logic [25:0]         rem_r, rem_nxt;
  logic [24:0]         span_r, span_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;

  logic signed [24:0]  v_e, lo_e, hi_e;
  logic                rej;
  logic [25:0]         rem_sh;

  assign v_e  = 25'(in_sample_value);
  assign lo_e = 25'(range_low);
  assign hi_e = 25'(range_high);
  assign rej  = (hi_e <= lo_e) || (v_e < lo_e) || (v_e > hi_e);
  assign rem_sh = {rem_r[24:0], quo_r[NumW-1]};

  assign in_ready = (state_r == F_IDLE);
  assign op_valid = (state_r == F_OUT);
  assign op_data  = op_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          op_nxt.cmd     = hks_pkg::cmd_t'(in_command);
          op_nxt.set_sel = in_set_select;
          op_nxt.reject  = rej;
          op_nxt.bin     = '0;
          quo_nxt  = {25'(v_e - lo_e), {hks_pkg::BinW{1'b0}}};
          rem_nxt  = '0;
          span_nxt = 25'(hi_e - lo_e);
          cnt_nxt  = CntW'(NumW);
          if (hks_pkg::cmd_t'(in_command) == hks_pkg::CMD_SAMPLE && !rej) begin
            state_nxt = F_DIV;
          end else begin
            state_nxt = F_OUT;
          end
        end
      end
      F_DIV: begin
        // One restoring division step per cycle.
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
        if (rem_sh >= {1'b0, span_r}) begin
          rem_nxt = rem_sh - {1'b0, span_r};
          quo_nxt[0] = 1'b1;
        end else begin
          rem_nxt = rem_sh;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          state_nxt = F_OUT;
          if (quo_nxt[NumW-1:hks_pkg::BinW] != '0) begin
            op_nxt.bin = '1;
          end else begin
            op_nxt.bin = quo_nxt[hks_pkg::BinW-1:0];
          end
        end
      end
      F_OUT: begin
        if (op_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    cnt_r  <= cnt_nxt;
  end
endmodule

// ===== src/hks_queue.sv =====
// Short queue between front and back end.
module hks_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  hks_pkg::op_t wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output hks_pkg::op_t rd_data
);
  localparam int PtrW = $clog2(hks_pkg::QueueDepth);

  hks_pkg::op_t  mem_r [hks_pkg::QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != (PtrW+1)'(hks_pkg::QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== src/hks_back.sv =====
// Back end: histogram memories, clear sweeps, compare walk and Q16 division.
module hks_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  output logic         op_ready,
  input  hks_pkg::op_t op_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_status,
  output logic [16:0]  out_distance
);
  localparam int BinW = hks_pkg::BinW;

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_INIT  = 10'b0000000010,
    B_SRD   = 10'b0000000100,
    B_SWR   = 10'b0000001000,
    B_CLR   = 10'b0000010000,
    B_CRD   = 10'b0000100000,
    B_CMUL  = 10'b0001000000,
    B_CDIF  = 10'b0010000000,
    B_QDIV  = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  hks_pkg::op_t     op_r, op_nxt;
  logic [BinW-1:0]  addr_r, addr_nxt;
  logic             last_r, last_nxt;
  logic [31:0]      ta_r, ta_nxt, tb_r, tb_nxt;
  logic [31:0]      sa_r, sa_nxt, sb_r, sb_nxt;
  logic [63:0]      pa_r, pa_nxt, pb_r, pb_nxt;
  logic [63:0]      best_r, best_nxt;
  logic [63:0]      den_r, den_nxt;
  logic [64:0]      rem_r, rem_nxt;
  logic [16:0]      q_r, q_nxt;
  logic [4:0]       qc_r, qc_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [16:0]      dist_r, dist_nxt;
  logic             rd_phase_r, rd_phase_nxt;

  logic [31:0] mem_a [hks_pkg::Bins];
  logic [31:0] mem_b [hks_pkg::Bins];
  logic [31:0] rda_r, rdb_r;
  logic        we_a, we_b;
  logic [BinW-1:0] waddr;
  logic [31:0] wdata;

  logic [32:0] sa_sum, sb_sum;
  logic [31:0] sa_cl, sb_cl, rd_sel, ta_pd, tb_pd;
  logic [63:0] diff;
  logic [64:0] rsh;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (we_b) mem_b[waddr] <= wdata;
    rda_r <= mem_a[addr_r];
    rdb_r <= mem_b[addr_r];
  end

  assign op_ready     = (state_r == B_IDLE);
  assign out_valid    = (state_r == B_OUT);
  assign out_status   = st_r;
  assign out_distance = dist_r;

  assign sa_sum = {1'b0, sa_r} + {1'b0, rda_r};
  assign sb_sum = {1'b0, sb_r} + {1'b0, rdb_r};
  assign sa_cl  = (sa_sum > {1'b0, ta_r}) ? ta_r : sa_sum[31:0];
  assign sb_cl  = (sb_sum > {1'b0, tb_r}) ? tb_r : sb_sum[31:0];
  assign diff   = (pa_r >= pb_r) ? pa_r - pb_r : pb_r - pa_r;
  assign rsh    = {rem_r[63:0], 1'b0};
  assign rd_sel = op_r.set_sel ? rdb_r : rda_r;
  assign ta_pd  = (ta_r == '1) ? ta_r : ta_r + 32'd1;
  assign tb_pd  = (tb_r == '1) ? tb_r : tb_r + 32'd1;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    addr_nxt = addr_r;
    last_nxt = last_r;
    ta_nxt = ta_r;
    tb_nxt = tb_r;
    sa_nxt = sa_r;
    sb_nxt = sb_r;
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    best_nxt = best_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    qc_nxt = qc_r;
    st_nxt = st_r;
    dist_nxt = dist_r;
    rd_phase_nxt = rd_phase_r;
    we_a = 1'b0;
    we_b = 1'b0;
    waddr = addr_r;
    wdata = '0;
    case (state_r)
      B_INIT: begin
        // Zero both sets after reset, one bin a cycle.
        we_a = 1'b1;
        we_b = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == '1) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (op_valid) begin
          op_nxt = op_data;
          st_nxt = hks_pkg::ST_OK;
          dist_nxt = '0;
          addr_nxt = op_data.bin;
          case (op_data.cmd)
            hks_pkg::CMD_SAMPLE: begin
              if (op_data.reject) begin
                st_nxt = hks_pkg::ST_RANGE;
                state_nxt = B_OUT;
              end else begin
                state_nxt = B_SRD;
              end
            end
            hks_pkg::CMD_CLEAR: begin
              addr_nxt = '0;
              state_nxt = B_CLR;
            end
            hks_pkg::CMD_COMPARE: begin
              if (ta_r == '0 || tb_r == '0) begin
                st_nxt = hks_pkg::ST_EMPTY;
                state_nxt = B_OUT;
              end else begin
                addr_nxt = '0;
                sa_nxt = '0;
                sb_nxt = '0;
                best_nxt = '0;
                last_nxt = 1'b0;
                rd_phase_nxt = 1'b1;
                den_nxt = ta_r * tb_r;
                state_nxt = B_CRD;
              end
            end
            default: state_nxt = B_OUT;
          endcase
        end
      end
      B_SRD: state_nxt = B_SWR;
      B_SWR: begin
        // Read data for the bin is now registered.
        wdata = (rd_sel == '1) ? rd_sel : rd_sel + 32'd1;
        if (op_r.set_sel) begin
          we_b = 1'b1;
          tb_nxt = tb_pd;
        end else begin
          we_a = 1'b1;
          ta_nxt = ta_pd;
        end
        state_nxt = B_OUT;
      end
      B_CLR: begin
        if (op_r.set_sel) we_b = 1'b1; else we_a = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == '1) begin
          if (op_r.set_sel) tb_nxt = '0; else ta_nxt = '0;
          state_nxt = B_OUT;
        end
      end
      B_CRD: begin
        // Wait for the registered read while rd_phase is set.
        if (rd_phase_r) begin
          rd_phase_nxt = 1'b0;
        end else begin
          sa_nxt = sa_cl;
          sb_nxt = sb_cl;
          last_nxt = (addr_r == '1);
          addr_nxt = addr_r + 1'b1;
          state_nxt = B_CMUL;
        end
      end
      B_CMUL: begin
        pa_nxt = sa_r * tb_r;
        pb_nxt = sb_r * ta_r;
        state_nxt = B_CDIF;
      end
      B_CDIF: begin
        if (diff > best_r) best_nxt = diff;
        if (last_r) begin
          rem_nxt = {1'b0, (diff > best_r) ? diff : best_r};
          q_nxt = '0;
          qc_nxt = 5'd16;
          state_nxt = B_QDIV;
        end else begin
          rd_phase_nxt = 1'b1;
          state_nxt = B_CRD;
        end
      end
      B_QDIV: begin
        if (rem_r[63:0] >= den_r && qc_r == 5'd16) begin
          dist_nxt = 17'd65536;
          state_nxt = B_OUT;
        end else begin
          q_nxt = {q_r[15:0], 1'b0};
          if (rsh >= {1'b0, den_r}) begin
            rem_nxt = rsh - {1'b0, den_r};
            q_nxt[0] = 1'b1;
          end else begin
            rem_nxt = rsh;
          end
          qc_nxt = qc_r - 1'b1;
          if (qc_r == 5'd1) begin
            dist_nxt = q_nxt;
            state_nxt = B_OUT;
          end
        end
      end
      B_OUT: begin
        if (out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      addr_r  <= '0;
      ta_r    <= '0;
      tb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      ta_r    <= ta_nxt;
      tb_r    <= tb_nxt;
    end
    op_r <= op_nxt;
    last_r <= last_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    best_r <= best_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    qc_r <= qc_nxt;
    st_r <= st_nxt;
    dist_r <= dist_nxt;
    rd_phase_r <= rd_phase_nxt;
  end
endmodule

// ===== src/histogram_ks_distance_top.sv =====
// Top level of the histogram KS distance block.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | command, set_select, sample_value
//  out_    | output    | out_valid / out_ready| status, distance
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// Sample: the bit-serial bin division (33 steps) and a read-modify-write of
// one bin. Clear: a sweep over the set, one bin a cycle. Compare: per bin a
// registered memory read, the multiply stage and a compare, then 16 Q16
// division steps. After reset both sets are zeroed by a sweep; items wait in
// the front and queue while config writes are taken. The front may classify
// the next item while the back works.
`include "histogram_ks_distance_top_defines.svh"
module histogram_ks_distance_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              in_set_select,
  input  logic signed [23:0] in_sample_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [16:0]       out_distance,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [23:0]       cfg_data
);
  logic signed [23:0] range_low_r, range_high_r;
  logic          f_valid, f_ready, q_valid, q_ready;
  hks_pkg::op_t  f_op, q_op;

  // Hold the range registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= 24'sd1048575;
    end else if (cfg_we) begin
      if (cfg_index == hks_pkg::CFG_RANGE_LOW) range_low_r <= cfg_data;
      else range_high_r <= cfg_data;
    end
  end

  hks_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_set_select,
    .in_sample_value,
    .range_low(range_low_r), .range_high(range_high_r),
    .op_valid(f_valid), .op_ready(f_ready), .op_data(f_op)
  );

  hks_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_op)
  );

  hks_back u_back (
    .clk, .rst_n, .op_valid(q_valid), .op_ready(q_ready), .op_data(q_op),
    .out_valid, .out_ready, .out_status, .out_distance
  );

  `HKS_ASSERT_IMPL(a_dist_range, out_valid, out_distance <= 17'd65536)
  `HKS_ASSERT_IMPL(a_dist_zero, out_valid && out_status != hks_pkg::ST_OK, out_distance == '0)
  `HKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))
endmodule

// ===== tb/sv/tb_histogram_ks_distance_top.sv =====
// Testbench for the histogram KS distance block: directed and random items checked against a predictor.
module tb_histogram_ks_distance_top;
  import hks_pkg::*;

  localparam int NumBins = 256;

  // Expected result of one item.
  typedef struct packed {
    status_t     status;
    logic [16:0] distance;
  } ks_result_t;

  // Scoreboard: mirrors both histograms and holds the results still owed.
  class ks_scoreboard;
    logic signed [23:0] lo_bound;
    logic signed [23:0] hi_bound;
    logic [31:0] bins_a [NumBins];
    logic [31:0] bins_b [NumBins];
    logic [31:0] count_a;
    logic [31:0] count_b;
    ks_result_t  owed_q [$];
    int          errors;

    function void reset_state();
      lo_bound = 24'sd0;
      hi_bound = 24'sd1048575;
      foreach (bins_a[i]) begin
        bins_a[i] = '0;
        bins_b[i] = '0;
      end
      count_a = '0;
      count_b = '0;
      owed_q.delete();
      errors = 0;
    endfunction

    function logic [31:0] sat_up(logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function logic [16:0] q16_ratio(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [16:0] q;
      rem = {1'b0, num};
      q = '0;
      if (num >= den) return 17'd65536;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    // Note an accepted input item and queue its expected result.
    function void note_item(cmd_t cmd, logic sel, logic signed [23:0] value);
      ks_result_t r;
      longint off, span, idx;
      logic [63:0] sum_a, sum_b, pa, pb, d, best;
      r.status = ST_OK;
      r.distance = '0;
      case (cmd)
        CMD_SAMPLE: begin
          if (hi_bound <= lo_bound || value < lo_bound || value > hi_bound) begin
            r.status = ST_RANGE;
          end else begin
            off = longint'(value) - longint'(lo_bound);
            span = longint'(hi_bound) - longint'(lo_bound);
            idx = off * NumBins / span;
            if (idx >= NumBins) idx = NumBins - 1;
            if (sel) begin
              bins_b[idx] = sat_up(bins_b[idx]);
              count_b = sat_up(count_b);
            end else begin
              bins_a[idx] = sat_up(bins_a[idx]);
              count_a = sat_up(count_a);
            end
          end
        end
        CMD_CLEAR: begin
          foreach (bins_a[i]) begin
            if (sel) bins_b[i] = '0;
            else bins_a[i] = '0;
          end
          if (sel) count_b = '0;
          else count_a = '0;
        end
        CMD_COMPARE: begin
          if (count_a == 0 || count_b == 0) begin
            r.status = ST_EMPTY;
          end else begin
            sum_a = '0;
            sum_b = '0;
            best = '0;
            for (int i = 0; i < NumBins; i++) begin
              sum_a += bins_a[i];
              sum_b += bins_b[i];
              if (sum_a > count_a) sum_a = count_a;
              if (sum_b > count_b) sum_b = count_b;
              pa = sum_a * count_b;
              pb = sum_b * count_a;
              d = (pa >= pb) ? pa - pb : pb - pa;
              if (d > best) best = d;
            end
            r.distance = q16_ratio(best, 64'(count_a) * 64'(count_b));
          end
        end
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    // Check a result against the oldest expectation.
    task check_result(logic [1:0] status, logic [16:0] distance);
      ks_result_t e;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, status);
        return;
      end
      e = owed_q.pop_front();
      if (status !== e.status) report_mismatch("status", e.status, status);
      if (distance !== e.distance) report_mismatch("distance", e.distance, distance);
    endtask

    task report_mismatch(string what, int unsigned want, int unsigned got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      errors++;
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_command;
  logic              in_set_select;
  logic signed [23:0] in_sample_value;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [16:0]       out_distance;
  logic              cfg_we;
  logic              cfg_index;
  logic [23:0]       cfg_data;

  ks_scoreboard ks_board;
  bit           gaps_on;   // random idling on both sides while set
  bit           stim_done;

  histogram_ks_distance_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_set_select   (in_set_select),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_distance    (out_distance),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Drive one item: optional gap, then hold valid until accepted.
  // Valid is left high afterwards; the next gap or drain() drops it.
  task automatic send_item(cmd_t cmd, logic sel, logic signed [23:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_set_select   <= sel;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
    ks_board.note_item(cmd, sel, value);
  endtask

  // Write one range register; only called with the block idle.
  // The caller drops the write enable after its last write.
  task automatic write_reg(logic idx, logic signed [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_RANGE_LOW) ks_board.lo_bound = value;
    else ks_board.hi_bound = value;
  endtask

  // Drop valid, wait for every owed result, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (ks_board.owed_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_range(logic signed [23:0] lo, logic signed [23:0] hi);
    drain();
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // Random value, mostly in range, with edges and noise mixed in.
  function automatic logic signed [23:0] pick_value();
    logic signed [23:0] lo, hi;
    longint span;
    lo = ks_board.lo_bound;
    hi = ks_board.hi_bound;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return 24'($urandom);
      3: return lo - 24'sd1;
      default: begin
        if (span <= 0) return 24'($urandom);
        return 24'(longint'(lo) + longint'({$urandom, $urandom} % (span + 1)));
      end
    endcase
  endfunction

  // Random phase: mostly samples into both sets, with compares, clears and now and then an unused command.
  task automatic random_phase(int n);
    cmd_t cmd;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 80) cmd = CMD_SAMPLE;
      else if (k < 92) cmd = CMD_COMPARE;
      else if (k < 97) cmd = CMD_CLEAR;
      else cmd = CMD_NOP;
      send_item(cmd, 1'($urandom), pick_value());
    end
  endtask

  // Result side: random stalls while gaps are on, check each accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) ks_board.check_result(out_status, out_distance);
      out_ready <= !gaps_on || ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    ks_board = new();
    ks_board.reset_state();
    gaps_on = 1'b1;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_NOP;
    in_set_select = 1'b0;
    in_sample_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RANGE_LOW;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty compare, extremes, last bin, clears, unused command.
    send_item(CMD_COMPARE, 1'b0, '0);
    send_item(CMD_SAMPLE, 1'b0, 24'sd0);
    send_item(CMD_COMPARE, 1'b0, '0);
    send_item(CMD_SAMPLE, 1'b1, 24'sd1048575);
    send_item(CMD_SAMPLE, 1'b1, 24'sd1048576);
    send_item(CMD_SAMPLE, 1'b0, -24'sd1);
    send_item(CMD_SAMPLE, 1'b0, 24'sh7FFFFF);
    send_item(CMD_SAMPLE, 1'b1, 24'sh800000);
    send_item(CMD_COMPARE, 1'b1, '0);
    send_item(CMD_NOP, 1'b1, 24'sh555555);
    send_item(CMD_CLEAR, 1'b1, '0);
    send_item(CMD_COMPARE, 1'b0, '0);
    send_item(CMD_SAMPLE, 1'b1, 24'sd524288);
    send_item(CMD_COMPARE, 1'b0, '0);
    send_item(CMD_CLEAR, 1'b0, '0);
    send_item(CMD_COMPARE, 1'b0, '0);

    // Full signed range, then degenerate ones that reject everything.
    set_range(24'sh800000, 24'sh7FFFFF);
    send_item(CMD_SAMPLE, 1'b0, 24'sh800000);
    send_item(CMD_SAMPLE, 1'b0, 24'sh7FFFFF);
    send_item(CMD_SAMPLE, 1'b1, 24'sd0);
    send_item(CMD_COMPARE, 1'b0, '0);
    set_range(24'sd100, 24'sd100);
    send_item(CMD_SAMPLE, 1'b0, 24'sd100);
    set_range(24'sd5, -24'sd5);
    send_item(CMD_SAMPLE, 1'b1, 24'sd0);

    // Random phases over several ranges; narrow spans stack counts per bin.
    set_range(-24'sd1000, 24'sd1000);
    random_phase(150);
    set_range(24'sd0, 24'sd1);
    random_phase(60);
    set_range(-24'sd300, 24'sd255);
    random_phase(130);
    set_range(24'sh800000, 24'sh7FFFFF);
    random_phase(100);
    set_range(24'sd10, 24'sd3);
    random_phase(20);
    set_range(24'($urandom_range(0, 1000)) - 24'sd2000, 24'($urandom_range(0, 5000)));
    random_phase(60);
    // Closing stretch without idling.
    gaps_on = 1'b0;
    random_phase(80);
    drain();
    stim_done = 1'b1;
  end

  // Report the outcome once stimulus is done and all results have arrived.
  initial begin
    wait (stim_done);
    if (ks_board.errors == 0 && ks_board.owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard: roughly 700 items plus stalls, with wide margin.
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
